FILE: hw/rtl/tmr_pkg.sv
`default_nettype none

package tmr_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int SLOT_FIELD     = 16;  // slot, slot_id and fired_mask cover 16 slots

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_REAP   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_INVALID  = 3'd2,
    ST_CANCELED = 3'd3,
    ST_EXPIRED  = 3'd4,
    ST_RUNNING  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_RUNNING  = 2'd1,
    MODE_CANCELED = 2'd2,
    MODE_EXPIRED  = 2'd3
  } mode_t;

  // Request broadcast to every cell
  typedef struct packed {
    logic valid;
    op_t  op;
  } cell_cmd_t;

  // What a cell shows of its slot
  typedef struct packed {
    logic  used;
    mode_t mode;
  } cell_view_t;

endpackage

`default_nettype wire

FILE: hw/rtl/multi_slot_countdown_timer.sv
`default_nettype none

// Countdown timer table with one cell per slot. A request is taken whenever
// start is high (busy never rises), so one request per clock is accepted, and
// its single result appears with out_valid for one cycle on the clock after
// acceptance; the receiver cannot stall it. Every cell updates at that clock:
// add takes the lowest free slot through a claim signal that ripples from cell
// to cell, tick expires running slots at count one or zero and decrements the
// others. Only the first min(NUM_SLOTS,16) slots are built.

module multi_slot_countdown_timer #(
  parameter int NUM_SLOTS  = tmr_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = tmr_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [15:0] in_seconds,
  input  wire logic [3:0]  in_slot_id,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [3:0]       out_slot,
  output logic [15:0]      out_fired_mask
);

  localparam int ACTIVE = (NUM_SLOTS < tmr_pkg::SLOT_FIELD) ? NUM_SLOTS
                                                             : tmr_pkg::SLOT_FIELD;

  tmr_pkg::cell_cmd_t    cmd;
  logic [31:0]           secs_ext;
  logic [COUNT_BITS-1:0] load;
  logic [ACTIVE:0]       claim;
  logic [ACTIVE-1:0]     grant;
  logic [ACTIVE-1:0]     fired;
  tmr_pkg::cell_view_t   view [ACTIVE];
  tmr_pkg::cell_view_t   sel_view;
  logic                  id_ok;
  logic [3:0]            grant_idx;
  logic [15:0]           fired_all;
  tmr_pkg::status_t      status;

  logic                  out_valid_r;
  logic [2:0]            status_r;
  logic [3:0]            slot_r;
  logic [15:0]           mask_r;

  assign busy      = 1'b0;
  assign cmd.valid = start && !busy;
  assign cmd.op    = tmr_pkg::op_t'(in_op);

  // Saturate the load at the count width
  assign secs_ext = 32'(in_seconds);
  assign load     = ((secs_ext >> COUNT_BITS) != 32'd0) ? '1 : secs_ext[COUNT_BITS-1:0];

  assign claim[0] = 1'b0;

  for (genvar g = 0; g < ACTIVE; g++) begin : g_cell
    tmr_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (in_slot_id == 4'(g)),
      .load      (load),
      .claim_in  (claim[g]),
      .claim_out (claim[g+1]),
      .grant     (grant[g]),
      .view      (view[g]),
      .fired     (fired[g])
    );
  end

  assign id_ok = {1'b0, in_slot_id} < 5'(ACTIVE);

  always_comb begin
    sel_view  = '0;
    grant_idx = '0;
    fired_all = '0;
    for (int i = 0; i < ACTIVE; i++) begin
      if (in_slot_id == 4'(i)) begin
        sel_view = view[i];
      end
      if (grant[i]) begin
        grant_idx = grant_idx | 4'(i);
      end
      fired_all[i] = fired[i];
    end
  end

  always_comb begin
    status = tmr_pkg::ST_OK;
    unique case (cmd.op)
      tmr_pkg::OP_ADD: begin
        if (!claim[ACTIVE]) begin
          status = tmr_pkg::ST_NOSPACE;
        end
      end
      tmr_pkg::OP_CANCEL: begin
        priority if (!id_ok || !sel_view.used) begin
          status = tmr_pkg::ST_INVALID;
        end else if (sel_view.mode == tmr_pkg::MODE_CANCELED) begin
          status = tmr_pkg::ST_CANCELED;
        end else if (sel_view.mode == tmr_pkg::MODE_EXPIRED) begin
          status = tmr_pkg::ST_EXPIRED;
        end else begin
          status = tmr_pkg::ST_OK;
        end
      end
      tmr_pkg::OP_REAP: begin
        priority if (!id_ok || !sel_view.used) begin
          status = tmr_pkg::ST_INVALID;
        end else if (sel_view.mode == tmr_pkg::MODE_RUNNING) begin
          status = tmr_pkg::ST_RUNNING;
        end else begin
          status = tmr_pkg::ST_OK;
        end
      end
      tmr_pkg::OP_TICK: begin
        status = tmr_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.valid;
    end
    status_r <= status;
    slot_r   <= grant_idx;
    mask_r   <= fired_all;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_slot       = slot_r;
  assign out_fired_mask = mask_r;

endmodule

`default_nettype wire

FILE: hw/rtl/tmr_cell.sv
`default_nettype none

module tmr_cell #(
  parameter int COUNT_BITS = tmr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tmr_pkg::cell_cmd_t    cmd,
  input  wire logic                  sel,
  input  wire logic [COUNT_BITS-1:0] load,
  input  wire logic                  claim_in,
  output logic                       claim_out,
  output logic                       grant,
  output tmr_pkg::cell_view_t        view,
  output logic                       fired
);

  logic                  used_r, used_nxt;
  tmr_pkg::mode_t        mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  running;

  assign running   = used_r && (mode_r == tmr_pkg::MODE_RUNNING);
  // A free cell raises the claim, so no cell further up the row grants
  assign claim_out = claim_in || !used_r;
  assign grant     = cmd.valid && (cmd.op == tmr_pkg::OP_ADD) && !claim_in && !used_r;
  assign fired     = cmd.valid && (cmd.op == tmr_pkg::OP_TICK) && running &&
                     (count_r <= COUNT_BITS'(1));

  assign view.used = used_r;
  assign view.mode = mode_r;

  always_comb begin
    used_nxt  = used_r;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    if (cmd.valid) begin
      unique case (cmd.op)
        tmr_pkg::OP_ADD: begin
          if (grant) begin
            used_nxt  = 1'b1;
            mode_nxt  = tmr_pkg::MODE_RUNNING;
            count_nxt = load;
          end
        end
        tmr_pkg::OP_CANCEL: begin
          if (sel && running) begin
            mode_nxt = tmr_pkg::MODE_CANCELED;
          end
        end
        tmr_pkg::OP_REAP: begin
          if (sel && used_r && !running) begin
            used_nxt = 1'b0;
          end
        end
        tmr_pkg::OP_TICK: begin
          if (fired) begin
            mode_nxt = tmr_pkg::MODE_EXPIRED;
          end else if (running) begin
            count_nxt = count_r - COUNT_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
    end
    mode_r  <= mode_nxt;
    count_r <= count_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tmr_checker.sv
`default_nettype none

module tmr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_op,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [3:0]  out_slot,
  input wire logic [15:0] out_fired_mask
);

  // Every accepted request gives exactly one result, on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without request");

  // A failed request claims nothing and fires nothing
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 3'(tmr_pkg::ST_OK)) |-> (out_slot == 4'd0 &&
    out_fired_mask == 16'd0))
    else $error("failed request shows slot or fired bits");

  // Only tick fires slots
  a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op != 2'(tmr_pkg::OP_TICK)) |=> (out_fired_mask == 16'd0))
    else $error("fired bits on a non-tick request");

  // Only add reports no space
  a_nospace_add: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op != 2'(tmr_pkg::OP_ADD)) |=>
    (out_status != 3'(tmr_pkg::ST_NOSPACE)))
    else $error("no space on a non-add request");

endmodule

bind multi_slot_countdown_timer tmr_checker u_tmr_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int       ACTIVE_SLOTS = (tmr_pkg::NUM_SLOTS_DEF < tmr_pkg::SLOT_FIELD) ?
                                      tmr_pkg::NUM_SLOTS_DEF : tmr_pkg::SLOT_FIELD;
  localparam longint   COUNT_MAX    = (longint'(1) << tmr_pkg::COUNT_BITS_DEF) - 1;
  localparam int       STALL_LIMIT  = 2000;
  localparam int       DRAIN_CYCLES = 4;

  typedef struct {
    tmr_pkg::status_t status;
    logic [3:0]       slot;
    logic [15:0]      fired_mask;
  } timer_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [15:0] in_seconds;
  logic [3:0]  in_slot_id;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [3:0]  out_slot;
  logic [15:0] out_fired_mask;

  // Shadow copy of the slot table
  bit              slot_busy [ACTIVE_SLOTS];
  tmr_pkg::mode_t  slot_state [ACTIVE_SLOTS];
  longint          slot_count [ACTIVE_SLOTS];

  timer_result_t pending_results[$];
  int            fail_count;
  int            idle_pct;
  int            stall_cycles;

  multi_slot_countdown_timer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_seconds     (in_seconds),
    .in_slot_id     (in_slot_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_fired_mask (out_fired_mask)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one request to the shadow table and queue the result it gives
  task automatic update_slot_table(input tmr_pkg::op_t op, input logic [15:0] secs,
                                   input logic [3:0] id);
    timer_result_t res;
    bit            claimed;
    res.status     = tmr_pkg::ST_OK;
    res.slot       = '0;
    res.fired_mask = '0;
    claimed        = 1'b0;
    case (op)
      tmr_pkg::OP_ADD: begin
        res.status = tmr_pkg::ST_NOSPACE;
        for (int i = 0; i < ACTIVE_SLOTS; i++) begin
          if (!claimed && !slot_busy[i]) begin
            claimed       = 1'b1;
            slot_busy[i]  = 1'b1;
            slot_state[i] = tmr_pkg::MODE_RUNNING;
            slot_count[i] = (longint'(secs) > COUNT_MAX) ? COUNT_MAX : longint'(secs);
            res.status    = tmr_pkg::ST_OK;
            res.slot      = 4'(i);
          end
        end
      end
      tmr_pkg::OP_CANCEL: begin
        if (int'(id) >= ACTIVE_SLOTS || !slot_busy[id]) res.status = tmr_pkg::ST_INVALID;
        else if (slot_state[id] == tmr_pkg::MODE_CANCELED) res.status = tmr_pkg::ST_CANCELED;
        else if (slot_state[id] == tmr_pkg::MODE_EXPIRED) res.status = tmr_pkg::ST_EXPIRED;
        else slot_state[id] = tmr_pkg::MODE_CANCELED;
      end
      tmr_pkg::OP_REAP: begin
        if (int'(id) >= ACTIVE_SLOTS || !slot_busy[id]) res.status = tmr_pkg::ST_INVALID;
        else if (slot_state[id] == tmr_pkg::MODE_RUNNING) res.status = tmr_pkg::ST_RUNNING;
        else slot_busy[id] = 1'b0;
      end
      default: begin
        for (int i = 0; i < ACTIVE_SLOTS; i++) begin
          if (slot_busy[i] && slot_state[i] == tmr_pkg::MODE_RUNNING) begin
            slot_count[i] -= 1;
            if (slot_count[i] <= 0) begin
              slot_state[i]     = tmr_pkg::MODE_EXPIRED;
              res.fired_mask[i] = 1'b1;
            end
          end
        end
      end
    endcase
    pending_results.push_back(res);
  endtask

  task automatic send_request(input tmr_pkg::op_t op, input logic [15:0] secs,
                              input logic [3:0] id);
    // idle cycles carry junk on the fields
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start      <= 1'b0;
      in_op      <= 2'($urandom());
      in_seconds <= 16'($urandom());
      in_slot_id <= 4'($urandom());
    end
    @(negedge clk);
    start      <= 1'b1;
    in_op      <= op;
    in_seconds <= secs;
    in_slot_id <= id;
    do @(posedge clk); while (busy);
    update_slot_table(op, secs, id);
  endtask

  task automatic test_slot_lifecycle();
    send_request(tmr_pkg::OP_ADD, 16'h0000, 4'hF);
    send_request(tmr_pkg::OP_ADD, 16'hFFFF, 4'h0);
    send_request(tmr_pkg::OP_REAP, 16'hFFFF, 4'd1);
    send_request(tmr_pkg::OP_TICK, 16'hFFFF, 4'hF);
    send_request(tmr_pkg::OP_CANCEL, 16'h0000, 4'd0);
    send_request(tmr_pkg::OP_CANCEL, 16'h5A5A, 4'd1);
    send_request(tmr_pkg::OP_CANCEL, 16'hA5A5, 4'd1);
    send_request(tmr_pkg::OP_REAP, 16'h0000, 4'd0);
    send_request(tmr_pkg::OP_REAP, 16'h0000, 4'd0);
    send_request(tmr_pkg::OP_CANCEL, 16'h0000, 4'hF);
  endtask

  task automatic test_table_full();
    // slot 1 stays canceled, so fifteen adds fill the table
    for (int i = 0; i < ACTIVE_SLOTS - 1; i++) begin
      send_request(tmr_pkg::OP_ADD, (i % 2 == 0) ? 16'd1 : 16'd0, 4'($urandom()));
    end
    send_request(tmr_pkg::OP_ADD, 16'd7, 4'h0);
    send_request(tmr_pkg::OP_TICK, 16'h0000, 4'h0);
  endtask

  task automatic test_random_traffic(input int count, input int pct);
    int           used_list[$];
    int           roll;
    bit           filling;
    tmr_pkg::op_t op;
    logic [15:0]  secs;
    logic [3:0]   id;
    idle_pct = pct;
    filling  = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 49) filling = !filling;
      used_list.delete();
      for (int i = 0; i < ACTIVE_SLOTS; i++) if (slot_busy[i]) used_list.push_back(i);
      roll = $urandom_range(99);
      if (roll < 10) op = tmr_pkg::op_t'($urandom_range(3));
      else if (filling) op = (roll < 50) ? tmr_pkg::OP_ADD :
                             (roll < 62) ? tmr_pkg::OP_CANCEL :
                             (roll < 75) ? tmr_pkg::OP_REAP : tmr_pkg::OP_TICK;
      else op = (roll < 22) ? tmr_pkg::OP_ADD : (roll < 45) ? tmr_pkg::OP_CANCEL :
                (roll < 75) ? tmr_pkg::OP_REAP : tmr_pkg::OP_TICK;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: secs = 16'($urandom_range(4));
        6, 7:             secs = 16'($urandom_range(40));
        default:          secs = 16'($urandom());
      endcase
      if (used_list.size() > 0 && $urandom_range(99) < 80)
        id = 4'(used_list[$urandom_range(used_list.size() - 1)]);
      else
        id = 4'($urandom());
      send_request(op, secs, id);
    end
  endtask

  // Check every result against the oldest queued one
  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status=%0d slot=%0d fired_mask=%h",
               out_status, out_slot, out_fired_mask);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          fail_count++;
        end
        if (out_fired_mask !== want.fired_mask) begin
          $error("fired_mask: expected %h, got %h", want.fired_mask, out_fired_mask);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[multi_slot_countdown_timer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = tmr_pkg::OP_ADD;
    in_seconds   = '0;
    in_slot_id   = '0;
    fail_count   = 0;
    idle_pct     = 0;
    stall_cycles = 0;
    for (int i = 0; i < ACTIVE_SLOTS; i++) begin
      slot_busy[i]  = 1'b0;
      slot_state[i] = tmr_pkg::MODE_RUNNING;
      slot_count[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 26;
    test_slot_lifecycle();
    test_table_full();
    test_random_traffic(200, 26);
    test_random_traffic(200, 50);
    test_random_traffic(200, 0);

    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[multi_slot_countdown_timer] OK");
    end else begin
      $display("[multi_slot_countdown_timer] ERROR");
    end
    $finish;
  end

endmodule
